@@ rtl/hrp_pkg.sv @@
`timescale 1ns / 1ps

package hrp_pkg;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    localparam logic [3:0] CNT_MAX  = 4'd15;
    localparam logic [3:0] LEN_GET  = 4'd3;
    localparam logic [3:0] LEN_POST = 4'd4;
    localparam logic [3:0] LEN_VER  = 4'd8;
    localparam logic [3:0] LEN_HOST = 4'd4;
    localparam logic [3:0] LEN_CONN = 4'd10;

    typedef enum logic [3:0] {
        PH_METHOD    = 4'd0,
        PH_URL       = 4'd1,
        PH_VERSION   = 4'd2,
        PH_VER_LF    = 4'd3,
        PH_HDR_START = 4'd4,
        PH_HDR_KEY   = 4'd5,
        PH_HDR_SKIP  = 4'd6,
        PH_HDR_VALUE = 4'd7,
        PH_HDR_LF    = 4'd8,
        PH_BODY      = 4'd9,
        PH_ERROR     = 4'd10
    } t_phase;

    typedef enum logic [3:0] {
        FK_DELIM   = 4'd0,
        FK_METHOD  = 4'd1,
        FK_URL     = 4'd2,
        FK_VERSION = 4'd3,
        FK_NAME    = 4'd4,
        FK_HOST    = 4'd5,
        FK_CONN    = 4'd6,
        FK_VALUE   = 4'd7,
        FK_BODY    = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        MC_UNKNOWN = 2'd0,
        MC_GET     = 2'd1,
        MC_POST    = 2'd2
    } t_method;

    typedef enum logic [1:0] {
        VD_PENDING   = 2'd0,
        VD_COMPLETE  = 2'd1,
        VD_MALFORMED = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        KK_OTHER = 2'd0,
        KK_HOST  = 2'd1,
        KK_CONN  = 2'd2
    } t_key;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] match_count;
        logic [1:0] match_flags;
        t_key       key_kind;
        logic [1:0] skip_left;
        logic       line_start_cr;
        t_method    method_seen;
        logic       malformed;
    } t_state;

    typedef struct packed {
        t_kind    kind;
        t_method  method;
        t_verdict verdict;
    } t_result;

    localparam t_state ST_RESET = '{
        phase:         PH_METHOD,
        match_count:   4'd0,
        match_flags:   2'b11,
        key_kind:      KK_OTHER,
        skip_left:     2'd0,
        line_start_cr: 1'b0,
        method_seen:   MC_UNKNOWN,
        malformed:     1'b0
    };

    function automatic logic [3:0] sat_inc(input logic [3:0] cnt);
        return (cnt < CNT_MAX) ? cnt + 4'd1 : cnt;
    endfunction

    function automatic logic hit_get(input logic [3:0] cnt, input logic [7:0] b);
        logic [7:0] c;
        case (cnt)
            4'd0:    c = "G";
            4'd1:    c = "E";
            4'd2:    c = "T";
            default: c = 8'h00;
        endcase
        return (cnt < LEN_GET) && (b == c);
    endfunction

    function automatic logic hit_post(input logic [3:0] cnt, input logic [7:0] b);
        logic [7:0] c;
        case (cnt)
            4'd0:    c = "P";
            4'd1:    c = "O";
            4'd2:    c = "S";
            4'd3:    c = "T";
            default: c = 8'h00;
        endcase
        return (cnt < LEN_POST) && (b == c);
    endfunction

    function automatic logic hit_ver(input logic [3:0] cnt, input logic [7:0] b);
        logic [7:0] c;
        case (cnt)
            4'd0:    c = "H";
            4'd1:    c = "T";
            4'd2:    c = "T";
            4'd3:    c = "P";
            4'd4:    c = "/";
            4'd5:    c = "1";
            4'd6:    c = ".";
            4'd7:    c = "1";
            default: c = 8'h00;
        endcase
        return (cnt < LEN_VER) && (b == c);
    endfunction

    function automatic logic hit_host(input logic [3:0] cnt, input logic [7:0] b);
        logic [7:0] c;
        case (cnt)
            4'd0:    c = "H";
            4'd1:    c = "o";
            4'd2:    c = "s";
            4'd3:    c = "t";
            default: c = 8'h00;
        endcase
        return (cnt < LEN_HOST) && (b == c);
    endfunction

    function automatic logic hit_conn(input logic [3:0] cnt, input logic [7:0] b);
        logic [7:0] c;
        case (cnt)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "n";
            4'd4:    c = "e";
            4'd5:    c = "c";
            4'd6:    c = "t";
            4'd7:    c = "i";
            4'd8:    c = "o";
            4'd9:    c = "n";
            default: c = 8'h00;
        endcase
        return (cnt < LEN_CONN) && (b == c);
    endfunction

endpackage

@@ rtl/hrp_step.sv @@
`timescale 1ns / 1ps

module hrp_step (
    input  hrp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output hrp_pkg::t_state  o_state,
    output hrp_pkg::t_result o_result
);

    hrp_pkg::t_state  n_st;
    hrp_pkg::t_kind   kind;
    logic             do_key;
    logic [3:0]       key_cnt;
    logic [1:0]       key_flg;
    logic [1:0]       skip;
    hrp_pkg::t_verdict verdict;

    always_comb begin
        n_st    = i_state;
        do_key  = 1'b0;
        key_cnt = i_state.match_count;
        key_flg = i_state.match_flags;
        skip    = i_state.skip_left;

        unique case (i_state.phase)
            hrp_pkg::PH_METHOD: begin
                if (i_byte == hrp_pkg::CH_SP) begin
                    if (i_state.match_flags[0] && i_state.match_count == hrp_pkg::LEN_GET) begin
                        n_st.method_seen = hrp_pkg::MC_GET;
                        n_st.phase       = hrp_pkg::PH_URL;
                    end else if (i_state.match_flags[1]
                                 && i_state.match_count == hrp_pkg::LEN_POST) begin
                        n_st.method_seen = hrp_pkg::MC_POST;
                        n_st.phase       = hrp_pkg::PH_URL;
                    end else begin
                        n_st.malformed = 1'b1;
                        n_st.phase     = hrp_pkg::PH_ERROR;
                    end
                end else begin
                    n_st.match_flags = i_state.match_flags
                        & {hrp_pkg::hit_post(i_state.match_count, i_byte),
                           hrp_pkg::hit_get(i_state.match_count, i_byte)};
                    n_st.match_count = hrp_pkg::sat_inc(i_state.match_count);
                end
            end
            hrp_pkg::PH_URL: begin
                if (i_byte == hrp_pkg::CH_SP) begin
                    n_st.phase       = hrp_pkg::PH_VERSION;
                    n_st.match_count = 4'd0;
                    n_st.match_flags = 2'b01;
                end
            end
            hrp_pkg::PH_VERSION: begin
                if (i_byte == hrp_pkg::CH_CR) begin
                    if (i_state.match_flags[0] && i_state.match_count == hrp_pkg::LEN_VER) begin
                        n_st.phase = hrp_pkg::PH_VER_LF;
                    end else begin
                        n_st.malformed = 1'b1;
                        n_st.phase     = hrp_pkg::PH_ERROR;
                    end
                end else begin
                    n_st.match_flags = i_state.match_flags
                        & {1'b1, hrp_pkg::hit_ver(i_state.match_count, i_byte)};
                    n_st.match_count = hrp_pkg::sat_inc(i_state.match_count);
                end
            end
            hrp_pkg::PH_VER_LF, hrp_pkg::PH_HDR_LF: begin
                if (i_byte == hrp_pkg::CH_LF) begin
                    n_st.phase = hrp_pkg::PH_HDR_START;
                end else begin
                    n_st.malformed = 1'b1;
                    n_st.phase     = hrp_pkg::PH_ERROR;
                end
            end
            hrp_pkg::PH_HDR_START: begin
                n_st.match_count = 4'd0;
                n_st.match_flags = 2'b11;
                if (i_last) begin
                    n_st.malformed = 1'b1;
                    n_st.phase     = hrp_pkg::PH_ERROR;
                end else if (i_byte == hrp_pkg::CH_CR) begin
                    n_st.line_start_cr = 1'b1;
                    n_st.phase         = hrp_pkg::PH_HDR_KEY;
                end else begin
                    n_st.phase = hrp_pkg::PH_HDR_KEY;
                    do_key     = 1'b1;
                    key_cnt    = 4'd0;
                    key_flg    = 2'b11;
                end
            end
            hrp_pkg::PH_HDR_KEY: begin
                if (i_state.line_start_cr) begin
                    n_st.line_start_cr = 1'b0;
                    if (i_byte == hrp_pkg::CH_LF) begin
                        n_st.phase = hrp_pkg::PH_BODY;
                    end else begin
                        // the pending cr counts as the first name byte
                        do_key  = 1'b1;
                        key_cnt = 4'd1;
                        key_flg = 2'b00;
                    end
                end else begin
                    do_key = 1'b1;
                end
            end
            hrp_pkg::PH_HDR_SKIP: begin
                if (skip != 2'd0) begin
                    skip = skip - 2'd1;
                end
                n_st.skip_left = skip;
                if (skip == 2'd0) begin
                    n_st.phase = hrp_pkg::PH_HDR_VALUE;
                end
            end
            hrp_pkg::PH_HDR_VALUE: begin
                if (i_byte == hrp_pkg::CH_CR) begin
                    n_st.phase = hrp_pkg::PH_HDR_LF;
                end
            end
            hrp_pkg::PH_BODY: begin
                n_st.phase = hrp_pkg::PH_BODY;
            end
            default: begin
                n_st.phase     = hrp_pkg::PH_ERROR;
                n_st.malformed = 1'b1;
            end
        endcase

        // header name byte, shared by line start and name phases
        if (do_key) begin
            if (i_byte == hrp_pkg::CH_COLON) begin
                if (key_flg[0] && key_cnt == hrp_pkg::LEN_HOST) begin
                    n_st.key_kind = hrp_pkg::KK_HOST;
                end else if (key_flg[1] && key_cnt == hrp_pkg::LEN_CONN) begin
                    n_st.key_kind = hrp_pkg::KK_CONN;
                end else begin
                    n_st.key_kind = hrp_pkg::KK_OTHER;
                end
                n_st.match_count = key_cnt;
                n_st.match_flags = key_flg;
                n_st.skip_left   = 2'd1;
                n_st.phase       = hrp_pkg::PH_HDR_SKIP;
            end else begin
                n_st.match_flags = key_flg
                    & {hrp_pkg::hit_conn(key_cnt, i_byte), hrp_pkg::hit_host(key_cnt, i_byte)};
                n_st.match_count = hrp_pkg::sat_inc(key_cnt);
            end
        end
    end

    always_comb begin
        kind = hrp_pkg::FK_DELIM;
        unique case (i_state.phase)
            hrp_pkg::PH_METHOD: begin
                if (i_byte != hrp_pkg::CH_SP) begin
                    kind = hrp_pkg::FK_METHOD;
                end
            end
            hrp_pkg::PH_URL: begin
                if (i_byte != hrp_pkg::CH_SP) begin
                    kind = hrp_pkg::FK_URL;
                end
            end
            hrp_pkg::PH_VERSION: begin
                if (i_byte != hrp_pkg::CH_CR) begin
                    kind = hrp_pkg::FK_VERSION;
                end
            end
            hrp_pkg::PH_HDR_START: begin
                if (!i_last && i_byte != hrp_pkg::CH_CR && i_byte != hrp_pkg::CH_COLON) begin
                    kind = hrp_pkg::FK_NAME;
                end
            end
            hrp_pkg::PH_HDR_KEY: begin
                if (!(i_state.line_start_cr && i_byte == hrp_pkg::CH_LF)
                    && i_byte != hrp_pkg::CH_COLON) begin
                    kind = hrp_pkg::FK_NAME;
                end
            end
            hrp_pkg::PH_HDR_VALUE: begin
                if (i_byte != hrp_pkg::CH_CR) begin
                    case (i_state.key_kind)
                        hrp_pkg::KK_HOST: kind = hrp_pkg::FK_HOST;
                        hrp_pkg::KK_CONN: kind = hrp_pkg::FK_CONN;
                        default:          kind = hrp_pkg::FK_VALUE;
                    endcase
                end
            end
            hrp_pkg::PH_BODY: begin
                kind = hrp_pkg::FK_BODY;
            end
            default: begin
                kind = hrp_pkg::FK_DELIM;
            end
        endcase

        verdict = n_st.malformed ? hrp_pkg::VD_MALFORMED : hrp_pkg::VD_PENDING;
        if (i_last) begin
            verdict = (n_st.phase == hrp_pkg::PH_BODY && !n_st.malformed)
                      ? hrp_pkg::VD_COMPLETE : hrp_pkg::VD_MALFORMED;
        end
        o_state          = i_last ? hrp_pkg::ST_RESET : n_st;
        o_result.kind    = kind;
        o_result.method  = n_st.method_seen;
        o_result.verdict = verdict;
    end

endmodule

@@ rtl/http_request_parser.sv @@
`timescale 1ns / 1ps

// channel  | valid   | stall   | payload
// ---------+---------+---------+--------------------------------------------------
// request  | i_valid | o_stall | i_data_byte, i_is_last
// result   | o_valid | i_stall | o_echo_byte, o_field_kind, o_method_code,
//          |         |         | o_verdict, o_end_mark
//
// one byte per cycle sustained while the result is not stalled
// the byte sits in an input register, is classified against the parser state in
// one step of logic and lands in the result register together with the state update
// synchronous active-low reset empties both registers and returns the parser to
// the method phase; the parser also returns there after each last byte
// a stalled result holds; the input stalls when both registers are full and the
// result is stalled

module http_request_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_echo_byte,
    output logic [3:0] o_field_kind,
    output logic [1:0] o_method_code,
    output logic [1:0] o_verdict,
    output logic       o_end_mark
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    hrp_pkg::t_state  r_state;
    hrp_pkg::t_state  n_state;
    hrp_pkg::t_result n_result;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    hrp_pkg::t_result r_out_result;
    logic             r_out_last;
    logic             out_free;
    logic             advance;
    logic             in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    hrp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= hrp_pkg::ST_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
        if (advance) begin
            r_out_byte   <= r_in_byte;
            r_out_result <= n_result;
            r_out_last   <= r_in_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_echo_byte   = r_out_byte;
    assign o_field_kind  = r_out_result.kind;
    assign o_method_code = r_out_result.method;
    assign o_verdict     = r_out_result.verdict;
    assign o_end_mark    = r_out_last;

endmodule
